[design/multi_field_range_first_match_core_macros.svh]
// Assertion macros used by the rule classifier controller.
`ifndef MULTI_FIELD_RANGE_FIRST_MATCH_CORE_MACROS_SVH
`define MULTI_FIELD_RANGE_FIRST_MATCH_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define MFRM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold whenever a trigger is seen.
`define MFRM_ASSERT_IMPLIES(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

`endif

[design/mfrm_pkg.sv]
// Types, codes and helpers shared by the rule classifier modules.
`default_nettype none

package mfrm_pkg;

  localparam int ROWS_DEF   = 64;
  localparam int PARAMS_DEF = 8;

  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_QUERY   = 2'd1;
  localparam logic [1:0] CMD_REPLACE = 2'd2;
  localparam logic [1:0] CMD_CHECK   = 2'd3;

  localparam logic [1:0] CFG_NUM_PARAMS       = 2'd0;
  localparam logic [1:0] CFG_MISSING_CODE     = 2'd1;
  localparam logic [1:0] CFG_INCOMPLETE_START = 2'd2;

  localparam logic [3:0]         NUM_PARAMS_RST       = 4'd1;
  localparam logic signed [31:0] MISSING_CODE_RST     = 32'sd8371200;
  localparam logic signed [31:0] INCOMPLETE_START_RST = 32'sd8112640;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         param_index;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic        matched;
    logic [5:0]  row_index;
    logic        missing_found;
    logic [14:0] incomplete_code;
  } out_t;

  typedef enum logic [1:0] {
    MODE_QUERY,
    MODE_REPL,
    MODE_CHECK
  } mode_t;

  // Token that walks along the cell chain, one per rule.
  typedef struct packed {
    logic        valid;
    mode_t       mode;
    logic        alive;
    logic        missing;
    logic        found;
    logic [14:0] code;
  } token_t;

  // Write commands broadcast from the controller to every cell.
  typedef struct packed {
    logic               app_en;
    logic               app_open;
    logic               q_en;
    logic [2:0]         pidx;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
  } bcast_t;

  // Integer part of a Q23.8 value, truncated towards zero, low 15 bits.
  function automatic logic [14:0] trunc_code(input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {b[31], b} + (b[31] ? 33'sd255 : 33'sd0);
    return s[22:8];
  endfunction

endpackage

`default_nettype wire

[design/multi_field_range_first_match_core.sv]
// Top level of the multi-field range classifier with first-match search.
// Usage:
// The input channel (in_valid, in_stall, in_data) takes one word per command:
// append a bound pair, store a query value, replace a bound, or check for
// incomplete bounds. The output channel (out_valid, out_stall, out_data)
// returns one word for a query word with last set and for each check.
// Appends and query values without last are taken in the idle state. A query, a
// check or a replace walks the stored rules through a chain of field cells,
// one rule entering per cycle; each cell holds the rule token in a read
// register and an output register. The block returns to idle as the result
// word is registered, or for a replace as its last rule leaves the chain.
// An empty table answers in the next cycle.
// While a result word waits under out_stall, appends, query values and
// replaces are still taken; queries with last and checks wait.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and should be written only while the block is idle.
// Reset empties the rule table and restores the register defaults; bound
// memory contents are not cleared and need no clearing pass.
`default_nettype none

module multi_field_range_first_match_core import mfrm_pkg::*; #(
  parameter int ROWS   = ROWS_DEF,
  parameter int PARAMS = PARAMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int RW = $clog2(ROWS);

  // Configuration registers.
  logic [3:0]         num_params;
  logic signed [31:0] missing_code;
  logic signed [31:0] incomplete_start;
  logic [4:0]         n_act;

  bcast_t             bc;
  logic [RW-1:0]      app_row;
  token_t             tok_c [PARAMS+1];
  logic [RW-1:0]      row_c [PARAMS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_params       <= NUM_PARAMS_RST;
      missing_code     <= MISSING_CODE_RST;
      incomplete_start <= INCOMPLETE_START_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_PARAMS:       num_params       <= cfg_data[3:0];
        CFG_MISSING_CODE:     missing_code     <= cfg_data;
        CFG_INCOMPLETE_START: incomplete_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fields above the number of cells simply act as the full cell count.
  assign n_act = ({1'b0, num_params} > 5'(PARAMS)) ? 5'(PARAMS) : {1'b0, num_params};

  mfrm_ctrl #(.ROWS(ROWS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .bc        (bc),
    .app_row   (app_row),
    .tok0      (tok_c[0]),
    .row0      (row_c[0]),
    .tok_o     (tok_c[PARAMS]),
    .row_o     (row_c[PARAMS])
  );

  // One cell per field; each rule token passes the cells in field order, so
  // the first failing field stops the rule just as an in-order scan would.
  for (genvar g = 0; g < PARAMS; g++) begin : g_cell
    mfrm_cell #(.ROWS(ROWS), .IDX(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bc        (bc),
      .app_row   (app_row),
      .n_act     (n_act),
      .miss_code (missing_code),
      .inc_start (incomplete_start),
      .tok_in    (tok_c[g]),
      .row_in    (row_c[g]),
      .tok_out   (tok_c[g+1]),
      .row_out   (row_c[g+1])
    );
  end

endmodule

`default_nettype wire

[design/mfrm_cell.sv]
// One field cell: holds one bound column and checks one field of each rule.
`default_nettype none

module mfrm_cell import mfrm_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int IDX  = 0,
  localparam int RW  = $clog2(ROWS)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bcast_t             bc,
  input  wire logic [RW-1:0]      app_row,
  input  wire logic [4:0]         n_act,
  input  wire logic signed [31:0] miss_code,
  input  wire logic signed [31:0] inc_start,
  input  wire token_t             tok_in,
  input  wire logic [RW-1:0]      row_in,
  output token_t                  tok_out,
  output logic [RW-1:0]           row_out
);

  logic [63:0]        mem [ROWS];
  logic [63:0]        rd;
  logic signed [31:0] q;
  token_t             tok_a;
  logic [RW-1:0]      row_a;
  token_t             tok_next;

  logic               active, hit_field, wb_en, fail, qmiss, lo_set, hi_set;
  logic               inc_lo, inc_hi;
  logic signed [31:0] lo, hi_raw, hi, rep_lo, rep_hi;

  assign active    = 5'(IDX) < n_act;
  assign hit_field = ({1'b0, bc.pidx} == 4'(IDX));

  assign lo     = rd[63:32];
  assign hi_raw = rd[31:0];
  assign lo_set = lo != miss_code;
  assign hi     = (hi_raw == miss_code && lo_set) ? lo : hi_raw;
  assign hi_set = hi != miss_code;
  assign qmiss  = q == miss_code;
  assign fail   = (lo_set && lo >= inc_start) || (hi_set && hi >= inc_start) ||
                  (lo_set && qmiss) || (lo_set && q < lo) || (hi_set && q > hi);
  assign inc_lo = lo >= inc_start && lo != miss_code;
  assign inc_hi = hi_raw >= inc_start && hi_raw != miss_code;

  assign rep_lo = (lo == bc.v1) ? bc.v2 : lo;
  assign rep_hi = (hi_raw == bc.v1) ? bc.v2 : hi_raw;
  assign wb_en  = tok_a.valid && tok_a.mode == MODE_REPL && active;

  always_comb begin
    tok_next = tok_a;
    if (tok_a.valid && active) begin
      case (tok_a.mode)
        MODE_QUERY: begin
          if (tok_a.alive) begin
            tok_next.missing = tok_a.missing | qmiss;
            tok_next.alive   = !fail;
          end
        end
        MODE_CHECK: begin
          if (!tok_a.found && (inc_lo || inc_hi)) begin
            tok_next.found = 1'b1;
            tok_next.code  = trunc_code(inc_lo ? lo : hi_raw);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wb_en) begin
      mem[row_a] <= {rep_lo, rep_hi};
    end else if (bc.app_en && (hit_field || bc.app_open)) begin
      mem[app_row] <= hit_field ? {bc.v1, bc.v2} : {miss_code, miss_code};
    end
    rd <= mem[row_in];
  end

  always_ff @(posedge clk) begin
    if (bc.q_en && hit_field) begin
      q <= bc.v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_a   <= '0;
      tok_out <= '0;
    end else begin
      tok_a   <= tok_in;
      tok_out <= tok_next;
    end
    row_a   <= row_in;
    row_out <= row_a;
  end

endmodule

`default_nettype wire

[design/mfrm_ctrl.sv]
// Command sequencer: rule table bookkeeping, row issue and result collection.
`default_nettype none

`include "multi_field_range_first_match_core_macros.svh"

module mfrm_ctrl import mfrm_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  localparam int RW  = $clog2(ROWS),
  localparam int CW  = $clog2(ROWS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_t           in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_t               out_data,
  output bcast_t             bc,
  output logic [RW-1:0]      app_row,
  output token_t             tok0,
  output logic [RW-1:0]      row0,
  input  wire token_t        tok_o,
  input  wire logic [RW-1:0] row_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  state_t             state;
  mode_t              mode;
  logic [CW-1:0]      rule_count, issue_cnt, recv_cnt;
  logic               row_open;
  logic signed [31:0] rep_old, rep_new;
  logic               hit, miss, found;
  logic [RW-1:0]      hit_row;
  logic [14:0]        code;

  logic               accept, needs_out, is_scan, room;
  logic               hit_next, miss_next, found_next, last_tok;
  logic [RW-1:0]      hit_row_next;
  logic [14:0]        code_next;

  assign needs_out = in_data.cmd == CMD_CHECK || (in_data.cmd == CMD_QUERY && in_data.last);
  assign in_stall  = (state != ST_IDLE) || (out_valid && needs_out);
  assign accept    = in_valid && !in_stall;
  assign is_scan   = needs_out || in_data.cmd == CMD_REPLACE;
  assign room      = rule_count < CW'(ROWS);

  always_comb begin
    bc          = '0;
    bc.pidx     = in_data.param_index;
    bc.v1       = (state == ST_IDLE) ? in_data.first_value : rep_old;
    bc.v2       = (state == ST_IDLE) ? in_data.second_value : rep_new;
    bc.app_en   = accept && in_data.cmd == CMD_APPEND && room;
    bc.app_open = !row_open;
    bc.q_en     = accept && in_data.cmd == CMD_QUERY;
  end
  assign app_row = rule_count[RW-1:0];

  always_comb begin
    tok0       = '0;
    tok0.valid = state == ST_ISSUE;
    tok0.mode  = mode;
    tok0.alive = 1'b1;
  end
  assign row0 = issue_cnt[RW-1:0];

  assign hit_next     = hit || (tok_o.valid && mode == MODE_QUERY && tok_o.alive);
  assign hit_row_next = hit ? hit_row : row_o;
  assign miss_next    = miss || (tok_o.valid && tok_o.missing);
  assign found_next   = found || (tok_o.valid && tok_o.found);
  assign code_next    = found ? code : tok_o.code;
  assign last_tok     = tok_o.valid && (recv_cnt + CW'(1) == rule_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      mode       <= MODE_QUERY;
      rule_count <= '0;
      row_open   <= 1'b0;
      out_valid  <= 1'b0;
      issue_cnt  <= '0;
      recv_cnt   <= '0;
      hit        <= 1'b0;
      miss       <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_data.cmd == CMD_APPEND && room) begin
            rule_count <= in_data.last ? rule_count + CW'(1) : rule_count;
            row_open   <= !in_data.last;
          end
          if (accept && is_scan) begin
            if (rule_count == '0) begin
              if (needs_out) begin
                out_valid <= 1'b1;
                out_data  <= '0;
              end
            end else begin
              state     <= ST_ISSUE;
              mode      <= (in_data.cmd == CMD_REPLACE) ? MODE_REPL :
                           (in_data.cmd == CMD_CHECK) ? MODE_CHECK : MODE_QUERY;
              rep_old   <= in_data.first_value;
              rep_new   <= in_data.second_value;
              issue_cnt <= '0;
              recv_cnt  <= '0;
              hit       <= 1'b0;
              miss      <= 1'b0;
              found     <= 1'b0;
              code      <= '0;
            end
          end
        end
        ST_ISSUE, ST_DRAIN: begin
          if (state == ST_ISSUE) begin
            issue_cnt <= issue_cnt + CW'(1);
            if (issue_cnt + CW'(1) == rule_count) begin
              state <= ST_DRAIN;
            end
          end
          if (tok_o.valid) begin
            recv_cnt <= recv_cnt + CW'(1);
            hit      <= hit_next;
            hit_row  <= hit_row_next;
            miss     <= miss_next;
            found    <= found_next;
            code     <= code_next;
          end
          if (last_tok) begin
            state <= ST_IDLE;
            if (mode != MODE_REPL) begin
              out_valid                <= 1'b1;
              out_data                 <= '0;
              if (mode == MODE_QUERY) begin
                out_data.matched       <= hit_next;
                out_data.row_index     <= hit_next ? 6'(hit_row_next) : 6'd0;
                out_data.missing_found <= !hit_next && miss_next;
              end else begin
                out_data.incomplete_code <= found_next ? code_next : 15'd0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MFRM_ASSERT_IMPLIES(a_no_stray_token, clk, rst, state == ST_IDLE, !tok_o.valid, "token left the chain while idle")
  `MFRM_ASSERT_ALWAYS(a_recv_bound, clk, rst, recv_cnt <= rule_count, "more rule tokens returned than rules")
  `MFRM_ASSERT_ALWAYS(a_count_bound, clk, rst, rule_count <= CW'(ROWS), "rule count above table size")

endmodule

`default_nettype wire

[dv/multi_field_range_first_match_core_tb.sv]
// Self-checking testbench for the multi-field range classifier core.
`timescale 1ns / 1ps
`default_nettype none

module multi_field_range_first_match_core_tb;
  import mfrm_pkg::*;

  localparam int ROWS   = ROWS_DEF;
  localparam int PARAMS = PARAMS_DEF;
  // A walk of a full table through the cell chain, with some margin.
  localparam int WALK_CYCLES = ROWS + 2 * PARAMS + 20;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  multi_field_range_first_match_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Words waiting to be driven, and result words the rule table should give.
  in_t  command_queue[$];
  out_t awaited_results[$];
  int   errors;
  bit   calm;  // when set, neither side idles or stalls

  // Shadow copy of the rule table, the query values and the registers.
  logic signed [31:0] lo_tab[ROWS * PARAMS];
  logic signed [31:0] hi_tab[ROWS * PARAMS];
  logic signed [31:0] query_vals[PARAMS];
  int                 rules_held;
  bit                 rule_open;
  logic [3:0]         field_count;
  logic signed [31:0] missing_val;
  logic signed [31:0] incomplete_val;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The number of fields in use; register values above PARAMS saturate.
  function automatic int fields_in_use();
    return (field_count > PARAMS) ? PARAMS : int'(field_count);
  endfunction

  function automatic bit is_incomplete(logic signed [31:0] b);
    return (b >= incomplete_val) && (b != missing_val);
  endfunction

  // Applies one accepted word to the shadow table. Returns 1 when the word
  // produces a result word, which is then written to res.
  function automatic bit classify_word(in_t w, output out_t res);
    int n;
    bit ok, missing, found;
    logic signed [31:0] lo, hi, q, b;
    bit lo_set, hi_set, qmiss;
    longint ip;
    n = fields_in_use();
    res = '0;
    case (w.cmd)
      CMD_APPEND: begin
        if (rules_held >= ROWS) return 0;
        if (!rule_open) begin
          for (int i = 0; i < PARAMS; i++) begin
            lo_tab[rules_held * PARAMS + i] = missing_val;
            hi_tab[rules_held * PARAMS + i] = missing_val;
          end
          rule_open = 1;
        end
        lo_tab[rules_held * PARAMS + w.param_index] = w.first_value;
        hi_tab[rules_held * PARAMS + w.param_index] = w.second_value;
        if (w.last) begin
          rules_held++;
          rule_open = 0;
        end
        return 0;
      end
      CMD_QUERY: begin
        query_vals[w.param_index] = w.first_value;
        if (!w.last) return 0;
        missing = 0;
        for (int r = 0; r < rules_held; r++) begin
          ok = 1;
          for (int i = 0; i < n && ok; i++) begin
            lo = lo_tab[r * PARAMS + i];
            hi = hi_tab[r * PARAMS + i];
            q = query_vals[i];
            qmiss = (q == missing_val);
            lo_set = (lo != missing_val);
            if (hi == missing_val && lo_set) hi = lo;
            hi_set = (hi != missing_val);
            if (qmiss) missing = 1;
            // An incomplete bound, a missing value against a set low bound,
            // or a value outside the bounds all fail the rule.
            if ((lo_set && lo >= incomplete_val) || (hi_set && hi >= incomplete_val))
              ok = 0;
            else if (lo_set && qmiss)
              ok = 0;
            else if (lo_set && q < lo)
              ok = 0;
            else if (hi_set && q > hi)
              ok = 0;
          end
          if (ok) begin
            res.matched = 1'b1;
            res.row_index = r[5:0];
            return 1;
          end
        end
        res.missing_found = missing;
        return 1;
      end
      CMD_REPLACE: begin
        for (int r = 0; r < rules_held; r++) begin
          for (int i = 0; i < n; i++) begin
            if (lo_tab[r * PARAMS + i] == w.first_value)
              lo_tab[r * PARAMS + i] = w.second_value;
            if (hi_tab[r * PARAMS + i] == w.first_value)
              hi_tab[r * PARAMS + i] = w.second_value;
          end
        end
        return 0;
      end
      default: begin
        found = 0;
        for (int r = 0; r < rules_held && !found; r++) begin
          for (int i = 0; i < n && !found; i++) begin
            if (is_incomplete(lo_tab[r * PARAMS + i])) begin
              b = lo_tab[r * PARAMS + i];
              found = 1;
            end else if (is_incomplete(hi_tab[r * PARAMS + i])) begin
              b = hi_tab[r * PARAMS + i];
              found = 1;
            end
          end
        end
        if (found) begin
          // Integer part truncated towards zero.
          ip = longint'(b);
          ip = (ip >= 0) ? ip / 256 : -((-ip) / 256);
          res.incomplete_code = ip[14:0];
        end
        return 1;
      end
    endcase
  endfunction

  // Driver: one word at a time from the command queue, with a random gap drawn
  // after about half of the accepted words outside calm phases. A stalled word is held unchanged.
  int send_gap;
  always @(posedge clk) begin
    out_t res;
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (classify_word(in_data, res)) awaited_results.push_back(res);
      end
      if (!(in_valid && in_stall)) begin
        if (in_valid && !in_stall && !calm && send_gap == 0 && $urandom_range(0, 1)) begin
          // Draw the idle time that follows this word.
          send_gap <= $urandom_range(1, 14);
          in_valid <= 1'b0;
        end else if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (command_queue.size() > 0) begin
          in_data <= command_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result word with the oldest expectation
  // and draws a fresh stall time for the next word.
  int stall_left;
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, out_data);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data.matched !== want.matched)
          $display("%0t: matched expected %0d actual %0d", $realtime, want.matched,
                   out_data.matched);
        if (out_data.row_index !== want.row_index)
          $display("%0t: row_index expected %0d actual %0d", $realtime, want.row_index,
                   out_data.row_index);
        if (out_data.missing_found !== want.missing_found)
          $display("%0t: missing_found expected %0d actual %0d", $realtime,
                   want.missing_found, out_data.missing_found);
        if (out_data.incomplete_code !== want.incomplete_code)
          $display("%0t: incomplete_code expected %0d actual %0d", $realtime,
                   want.incomplete_code, out_data.incomplete_code);
        if (out_data !== want) errors++;
      end
      stall_left <= calm ? 0 : $urandom_range(0, 14);
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic push_word(logic [1:0] cmd, logic [2:0] pidx, logic [31:0] v1,
                           logic [31:0] v2, logic last);
    in_t w;
    w.cmd = cmd;
    w.param_index = pidx;
    w.first_value = v1;
    w.second_value = v2;
    w.last = last;
    command_queue.push_back(w);
  endtask

  // Values concentrated around the interesting points: small numbers so that
  // ranges overlap, the two register values and the extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return missing_val;
      1:       return incomplete_val;
      2:       return incomplete_val - 1;
      3:       return $urandom();
      4:       return 32'h7fff_ffff;
      5:       return 32'h8000_0000;
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (command_queue.size() != 0 || in_valid || awaited_results.size() != 0);
    // A replace gives no result word, so let any walk still running finish.
    repeat (WALK_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NUM_PARAMS:   field_count = value[3:0];
      CFG_MISSING_CODE: missing_val = value;
      default:          incomplete_val = value;
    endcase
  endtask

  // Random traffic: mostly whole rules and whole queries with random content,
  // with checks, replaces and the odd stray word mixed in.
  task automatic random_traffic(int words);
    int sent, kind, k;
    logic [31:0] lo, old_bound;
    old_bound = 0;
    sent = 0;
    while (sent < words) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        k = $urandom_range(1, 8);
        for (int j = 0; j < k; j++) begin
          lo = pick_value();
          old_bound = lo;
          push_word(CMD_APPEND, 3'($urandom_range(0, 7)), lo,
                    $urandom_range(0, 3) == 0 ? pick_value() : lo + $urandom_range(0, 500),
                    j == k - 1);
        end
        sent += k;
      end else if (kind < 75) begin
        k = $urandom_range(1, 8);
        for (int j = 0; j < k; j++)
          push_word(CMD_QUERY, 3'($urandom_range(0, 7)), pick_value(), $urandom(),
                    j == k - 1);
        sent += k;
      end else if (kind < 85) begin
        push_word(CMD_CHECK, 3'($urandom()), $urandom(), $urandom(), 1'($urandom()));
        sent++;
      end else if (kind < 93) begin
        push_word(CMD_REPLACE, 3'($urandom()),
                  $urandom_range(0, 1) ? old_bound : pick_value(),
                  pick_value(), 1'($urandom()));
        sent++;
      end else begin
        push_word(2'($urandom()), 3'($urandom()), $urandom(), $urandom(), 1'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    errors = 0;
    calm = 0;
    rules_held = 0;
    rule_open = 0;
    field_count = NUM_PARAMS_RST;
    missing_val = MISSING_CODE_RST;
    incomplete_val = INCOMPLETE_START_RST;
    for (int i = 0; i < PARAMS; i++) query_vals[i] = 0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset defaults. Every query value is written
    // first so that no search ever reads an unwritten one.
    for (int i = 0; i < PARAMS; i++) push_word(CMD_QUERY, 3'(i), 0, 0, 1'b0);
    push_word(CMD_QUERY, 3'd0, 0, 0, 1'b1);                     // empty table
    push_word(CMD_CHECK, 3'd0, 0, 0, 1'b0);                     // nothing incomplete
    push_word(CMD_APPEND, 3'd0, -100, 100, 1'b1);               // rule 0
    push_word(CMD_APPEND, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    push_word(CMD_APPEND, 3'd7, 32'h8000_0000, 32'h7fff_ffff, 1'b1); // rule 1
    push_word(CMD_APPEND, 3'd0, 50, MISSING_CODE_RST, 1'b1);    // high takes low
    push_word(CMD_APPEND, 3'd0, INCOMPLETE_START_RST, 0, 1'b1); // incomplete low
    push_word(CMD_QUERY, 3'd0, 50, 0, 1'b1);
    push_word(CMD_QUERY, 3'd0, 32'h8000_0000, 0, 1'b1);
    push_word(CMD_QUERY, 3'd0, MISSING_CODE_RST, 0, 1'b1);      // missing value
    push_word(CMD_CHECK, 3'd0, 0, 0, 1'b1);
    push_word(CMD_REPLACE, 3'd0, -100, 32'hffff_0000, 1'b0);
    push_word(CMD_REPLACE, 3'd0, INCOMPLETE_START_RST, 7, 1'b0);
    push_word(CMD_QUERY, 3'd0, -200, 0, 1'b1);
    push_word(CMD_CHECK, 3'd0, 0, 0, 1'b0);
    wait_idle();

    // Phases with different register settings, extremes among them. Tables
    // fill during the run, so later phases also see appends ignored.
    for (int phase = 0; phase < 7; phase++) begin
      calm = (phase == 2);
      case (phase)
        0: begin
          write_reg(CFG_NUM_PARAMS, 3);
          write_reg(CFG_MISSING_CODE, MISSING_CODE_RST);
          write_reg(CFG_INCOMPLETE_START, INCOMPLETE_START_RST);
        end
        1: begin
          write_reg(CFG_NUM_PARAMS, 8);
          write_reg(CFG_MISSING_CODE, 32'h8000_0000);
          write_reg(CFG_INCOMPLETE_START, 32'h7fff_ffff);
        end
        2: begin
          write_reg(CFG_NUM_PARAMS, 0);
          write_reg(CFG_INCOMPLETE_START, 1000);
        end
        3: begin
          write_reg(CFG_NUM_PARAMS, 15);
          write_reg(CFG_MISSING_CODE, 32'h7fff_ffff);
          write_reg(CFG_INCOMPLETE_START, 32'h8000_0000);
        end
        4: begin
          write_reg(CFG_NUM_PARAMS, 1);
          write_reg(CFG_MISSING_CODE, 0);
          write_reg(CFG_INCOMPLETE_START, -500);
        end
        5: begin
          write_reg(CFG_NUM_PARAMS, 2);
          write_reg(CFG_MISSING_CODE, -1);
          write_reg(CFG_INCOMPLETE_START, 1500);
        end
        default: begin
          write_reg(CFG_NUM_PARAMS, 5);
          write_reg(CFG_MISSING_CODE, MISSING_CODE_RST);
          write_reg(CFG_INCOMPLETE_START, 32'hffff_8000);
        end
      endcase
      random_traffic(215);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
